@@ src/line_palette_framebuffer_defines.svh @@
// assertion macros for the line palette frame buffer
// used by line_palette_framebuffer.sv, needs a clk and rst in scope
`ifndef LINE_PALETTE_FRAMEBUFFER_DEFINES_SVH
`define LINE_PALETTE_FRAMEBUFFER_DEFINES_SVH

// condition that holds at every edge outside reset
`define LPF_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence that holds in the cycle after a trigger
`define LPF_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

@@ src/lpf_pkg.sv @@
// types and constants of the line palette frame buffer
// no dependencies
package lpf_pkg;

  localparam int NUM_LINES       = 256;
  localparam int LINE_BYTES      = 256;
  localparam int PALETTE_BYTES   = 32;
  localparam int PIXEL_BYTES_END = 212;
  localparam int LAST_ROW        = 359;
  localparam int WORDS           = NUM_LINES * LINE_BYTES / 2;
  localparam int WORD_ADDR_W     = $clog2(WORDS);
  localparam int LINE_W          = $clog2(NUM_LINES);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FETCH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_PIX,
    S_PAL
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] scanline;
    logic [7:0] offset;
    logic [7:0] write_data;
    logic [8:0] row;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rsp_t;

endpackage

@@ src/lpf_cmd_if.sv @@
// command channel of the line palette frame buffer
// depends on lpf_pkg
interface lpf_cmd_if (input logic clk);
  logic            valid;
  logic            ready;
  lpf_pkg::cmd_t   item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ src/lpf_rsp_if.sv @@
// response channel of the line palette frame buffer
// depends on lpf_pkg
interface lpf_rsp_if (input logic clk);
  logic            valid;
  logic            ready;
  lpf_pkg::rsp_t   item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ src/line_palette_framebuffer.sv @@
// line palette frame buffer: video memory with per-line palettes
// depends on lpf_pkg, lpf_cmd_if, lpf_rsp_if and line_palette_framebuffer_defines.svh
//
// cmd carries cpu reads, cpu writes and pixel fetches, rsp returns one item
// for every command item. the memory is 32768 words of 16 bits, one word per
// byte pair of a line, with byte write enables and a registered read.
// a write, an unused operation or an out of range fetch answers in the cycle
// after it is taken. a cpu read answers from S_READ, after one memory read.
// a pixel fetch answers from S_PAL after two memory reads: the pixel byte
// read, then the palette word read, each through the single memory read port.
// commands are taken one at a time: cmd is ready only in S_IDLE, when the
// output register is free.
// the response sits in an output register; while rsp is stalled the block
// finishes its current memory read and then holds, and cmd is not ready.
// reset clears the control state only, the memory contents stay undefined
// until written.
`include "line_palette_framebuffer_defines.svh"

module line_palette_framebuffer (
  input logic        clk,
  input logic        rst,
  lpf_cmd_if.sink    cmd,
  lpf_rsp_if.source  rsp
);

  localparam int AW = lpf_pkg::WORD_ADDR_W;

  lpf_pkg::state_t state, state_next;

  logic [15:0]   mem [lpf_pkg::WORDS];
  logic [15:0]   rd_word;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_hi;

  logic                       rsp_valid;
  lpf_pkg::rsp_t              rsp_item;
  lpf_pkg::rsp_t              res;
  logic                       load;
  logic                       out_free;
  logic                       accept;
  logic [8:0]                 pix;
  logic                       pix_ok;
  logic                       row_ok;
  logic [lpf_pkg::LINE_W-1:0] line;
  logic                       sel_hi;
  logic                       odd_row;
  logic                       pal_ok;
  logic                       pal_ok_next;
  logic [7:0]                 pix_byte;
  logic [3:0]                 nib;
  logic [7:0]                 pal_lo;
  logic [7:0]                 pal_hi;

  assign out_free  = !rsp_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.item  = rsp_item;

  assign row_ok = cmd.item.row <= 9'(lpf_pkg::LAST_ROW);
  assign pix    = 9'(lpf_pkg::PALETTE_BYTES) + ((9'(lpf_pkg::LAST_ROW) - cmd.item.row) >> 1);
  assign pix_ok = pix < 9'(lpf_pkg::PIXEL_BYTES_END);

  assign wr_addr = {cmd.item.scanline[lpf_pkg::LINE_W-1:0], cmd.item.offset[7:1]};
  assign wr_hi   = cmd.item.offset[0];

  assign pix_byte    = sel_hi ? rd_word[15:8] : rd_word[7:0];
  assign nib         = odd_row ? pix_byte[7:4] : pix_byte[3:0];
  assign pal_ok_next = {2'b00, nib, 1'b1} < 7'(lpf_pkg::PALETTE_BYTES);
  assign pal_lo      = rd_word[7:0];
  assign pal_hi      = rd_word[15:8];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_hi) begin
        mem[wr_addr][15:8] <= cmd.item.write_data;
      end else begin
        mem[wr_addr][7:0] <= cmd.item.write_data;
      end
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpf_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_item <= res;
    end
    if (accept) begin
      line    <= cmd.item.scanline[lpf_pkg::LINE_W-1:0];
      sel_hi  <= (cmd.item.operation == lpf_pkg::OP_READ) ? cmd.item.offset[0] : pix[0];
      odd_row <= cmd.item.row[0];
    end
    if (state == lpf_pkg::S_PIX) begin
      pal_ok <= pal_ok_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    load       = 1'b0;
    res        = '0;
    cmd.ready  = 1'b0;
    unique case (state)
      lpf_pkg::S_IDLE: begin
        cmd.ready = out_free;
        if (cmd.valid && out_free) begin
          unique case (cmd.item.operation)
            lpf_pkg::OP_READ: begin
              rd_en      = 1'b1;
              rd_addr    = wr_addr;
              state_next = lpf_pkg::S_READ;
            end
            lpf_pkg::OP_WRITE: begin
              wr_en = 1'b1;
              load  = 1'b1;
            end
            lpf_pkg::OP_FETCH: begin
              if (row_ok && pix_ok) begin
                rd_en      = 1'b1;
                rd_addr    = {cmd.item.scanline[lpf_pkg::LINE_W-1:0], pix[7:1]};
                state_next = lpf_pkg::S_PIX;
              end else begin
                load = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      lpf_pkg::S_READ: begin
        if (out_free) begin
          load          = 1'b1;
          res.read_data = pix_byte;
          state_next    = lpf_pkg::S_IDLE;
        end
      end
      lpf_pkg::S_PIX: begin
        rd_en      = 1'b1;
        rd_addr    = {line, 3'b000, nib};
        state_next = lpf_pkg::S_PAL;
      end
      lpf_pkg::S_PAL: begin
        if (out_free) begin
          load = 1'b1;
          if (pal_ok) begin
            res.red   = {pal_lo[3:0], pal_lo[3:0]};
            res.green = {pal_hi[7:4], pal_hi[7:4]};
            res.blue  = {pal_hi[3:0], pal_hi[3:0]};
          end
          state_next = lpf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lpf_pkg::S_IDLE;
      end
    endcase
  end

  `LPF_ASSERT(a_no_rd_wr_same_cycle, !(rd_en && wr_en), "read and write issued together")
  `LPF_ASSERT_NEXT(a_pix_to_pal, state == lpf_pkg::S_PIX, state == lpf_pkg::S_PAL, "palette read skipped")
  `LPF_ASSERT_NEXT(a_pal_hold, state == lpf_pkg::S_PAL && !out_free, state == lpf_pkg::S_PAL && $stable(rd_word), "palette word lost while stalled")
  `LPF_ASSERT_NEXT(a_bad_row_zero, accept && cmd.item.operation == lpf_pkg::OP_FETCH && !row_ok, rsp.valid && rsp.item.red == 8'd0 && rsp.item.blue == 8'd0, "out of range fetch not answered with zero")

endmodule
